FILE: hdl/siemon_iv_projection_assert.svh
// Assertion macros for the Siemon IV projection block.
// Expects clk_i and rst_ni in the scope that uses them; empty under SYNTHESIS.
`ifndef SIEMON_IV_PROJECTION_ASSERT_SVH
`define SIEMON_IV_PROJECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define SIVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SIVP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SIVP_ASSERT(lbl, prop, msg)
`define SIVP_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hdl/sivp_pkg.sv
// Shared types, fixed-point constants and the CORDIC angle function for the
// Siemon IV projection block. No dependencies.
package sivp_pkg;

  localparam int unsigned CoordW          = 32;
  localparam int unsigned CordicStagesDef = 28;
  localparam int unsigned QF              = 28;
  localparam int unsigned IsqrtSteps      = 32;
  localparam int unsigned DivSteps        = 64;

  typedef logic signed [63:0] q_t;

  localparam q_t QOne    = 64'sd268435456;
  localparam q_t KQ      = 64'sd163008219;
  localparam q_t CxQ     = 64'sd254704982;
  localparam q_t CyQ     = 64'sd565812208;
  localparam q_t IcyQ    = 64'sd127352491;
  localparam q_t PiQ     = 64'sd843314857;
  localparam q_t TwoPiQ  = 64'sd1686629713;
  localparam q_t HalfPiQ = 64'sd421657428;
  localparam q_t SatBig  = 64'sd1099511627776;

  localparam logic OpFwd = 1'b0;
  localparam logic OpInv = 1'b1;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StClamp = 2'd1;
  localparam logic [1:0] StErr   = 2'd2;

  typedef struct packed {
    logic                     operation;
    logic signed [CoordW-1:0] coord_a;
    logic signed [CoordW-1:0] coord_b;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_a;
    logic signed [CoordW-1:0] out_b;
    logic [1:0]               status;
  } out_t;

  // Per-item context through the front half of the pipe.
  typedef struct packed {
    logic op;
    logic clamp;
    logic neg;
    q_t   a;   // lam or x
    q_t   h;   // half angle (fwd) or t (inv)
    q_t   p;   // Cx*lam (fwd) or cos(phi) (inv)
    q_t   w;   // cos(phi/2) from the square root
  } ctx_t;

  typedef struct packed {
    logic op;
    logic clamp;
    q_t   rb;
    q_t   den;
  } m2tag_t;

  typedef struct packed {
    logic op;
    logic clamp;
    logic sgn;
    logic dz;
    logic nz;
    logic nneg;
    q_t   rb;
  } dvtag_t;

  function automatic q_t atan_q(input int unsigned i);
    case (i)
      0: atan_q = 64'sd210828714;
      1: atan_q = 64'sd124459457;
      2: atan_q = 64'sd65760959;
      3: atan_q = 64'sd33381290;
      4: atan_q = 64'sd16755422;
      5: atan_q = 64'sd8385879;
      6: atan_q = 64'sd4193963;
      7: atan_q = 64'sd2097109;
      8: atan_q = 64'sd1048571;
      9: atan_q = 64'sd524287;
      10: atan_q = 64'sd262144;
      default: atan_q = (i <= QF) ? (64'sd1 <<< (QF - i)) : 64'sd0;
    endcase
  endfunction

endpackage

FILE: hdl/sivp_mul.sv
// Two-stage 64-bit multiplier: low 64 product bits, then arithmetic shift by QF.
// Built from three 32x32 partial products. Uses sivp_pkg.
module sivp_mul #(
  parameter int unsigned TagW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sivp_pkg::q_t         a_i,
  input  sivp_pkg::q_t         b_i,
  input  logic [TagW-1:0]      tag_i,
  output logic                 valid_o,
  output sivp_pkg::q_t         p_o,
  output logic [TagW-1:0]      tag_o
);

  logic [63:0]     pp0_d, pp0_q;
  logic [31:0]     pp1_d, pp1_q, pp2_d, pp2_q;
  logic [TagW-1:0] tag1_q, tag2_q;
  logic            v1_q, v2_q;
  logic [63:0]     sum;
  sivp_pkg::q_t    p_d, p_q;

  assign pp0_d = 64'(a_i[31:0]) * 64'(b_i[31:0]);
  assign pp1_d = 32'(a_i[31:0] * b_i[63:32]);
  assign pp2_d = 32'(a_i[63:32] * b_i[31:0]);

  assign sum = pp0_q + {32'(pp1_q + pp2_q), 32'd0};
  assign p_d = $signed(sum) >>> sivp_pkg::QF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp0_q  <= pp0_d;
    pp1_q  <= pp1_d;
    pp2_q  <= pp2_d;
    tag1_q <= tag_i;
    p_q    <= p_d;
    tag2_q <= tag1_q;
  end

  assign valid_o = v2_q;
  assign p_o     = p_q;
  assign tag_o   = tag2_q;

endmodule

FILE: hdl/sivp_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Uses sivp_pkg for the step count.
module sivp_isqrt #(
  parameter int unsigned TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [63:0]     v_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [63:0]     r_o,
  output logic [TagW-1:0] tag_o
);

  localparam int unsigned Steps = sivp_pkg::IsqrtSteps;

  logic [63:0]     v_q   [Steps];
  logic [63:0]     r_q   [Steps];
  logic [TagW-1:0] tag_q [Steps];
  logic            vld_q [Steps];
  logic [63:0]     v_in  [Steps];
  logic [63:0]     r_in  [Steps];
  logic [TagW-1:0] t_in  [Steps];
  logic            vl_in [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in[k]  = v_i;
      assign r_in[k]  = '0;
      assign t_in[k]  = tag_i;
      assign vl_in[k] = valid_i;
    end else begin : g_next
      assign v_in[k]  = v_q[k-1];
      assign r_in[k]  = r_q[k-1];
      assign t_in[k]  = tag_q[k-1];
      assign vl_in[k] = vld_q[k-1];
    end

    assign trial = r_in[k] + Bit;
    assign ge    = v_in[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vl_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      v_q[k]   <= ge ? v_in[k] - trial : v_in[k];
      r_q[k]   <= ge ? (r_in[k] >> 1) + Bit : r_in[k] >> 1;
      tag_q[k] <= t_in[k];
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign r_o     = r_q[Steps-1];
  assign tag_o   = tag_q[Steps-1];

endmodule

FILE: hdl/sivp_cordic.sv
// Pipelined CORDIC, rotation or vectoring chosen per item, one stage per
// iteration. Uses sivp_pkg for the angle function.
module sivp_cordic #(
  parameter int unsigned Stages = sivp_pkg::CordicStagesDef,
  parameter int unsigned TagW   = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic            vec_i,
  input  sivp_pkg::q_t    x_i,
  input  sivp_pkg::q_t    y_i,
  input  sivp_pkg::q_t    z_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output sivp_pkg::q_t    x_o,
  output sivp_pkg::q_t    y_o,
  output sivp_pkg::q_t    z_o,
  output logic [TagW-1:0] tag_o
);

  sivp_pkg::q_t    x_q [Stages], y_q [Stages], z_q [Stages];
  sivp_pkg::q_t    x_in [Stages], y_in [Stages], z_in [Stages];
  logic            m_q [Stages], m_in [Stages];
  logic            vld_q [Stages], vl_in [Stages];
  logic [TagW-1:0] tag_q [Stages], t_in [Stages];

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    localparam sivp_pkg::q_t Ang = sivp_pkg::atan_q(i);
    sivp_pkg::q_t dx, dy;
    logic         pos;

    if (i == 0) begin : g_first
      assign x_in[i]  = x_i;
      assign y_in[i]  = y_i;
      assign z_in[i]  = z_i;
      assign m_in[i]  = vec_i;
      assign vl_in[i] = valid_i;
      assign t_in[i]  = tag_i;
    end else begin : g_next
      assign x_in[i]  = x_q[i-1];
      assign y_in[i]  = y_q[i-1];
      assign z_in[i]  = z_q[i-1];
      assign m_in[i]  = m_q[i-1];
      assign vl_in[i] = vld_q[i-1];
      assign t_in[i]  = tag_q[i-1];
    end

    assign dx  = y_in[i] >>> i;
    assign dy  = x_in[i] >>> i;
    // rotate toward zero residual angle, or toward zero y when vectoring
    assign pos = m_in[i] ? y_in[i][63] : !z_in[i][63];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vl_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i]   <= pos ? x_in[i] - dx : x_in[i] + dx;
      y_q[i]   <= pos ? y_in[i] + dy : y_in[i] - dy;
      z_q[i]   <= pos ? z_in[i] - Ang : z_in[i] + Ang;
      m_q[i]   <= m_in[i];
      tag_q[i] <= t_in[i];
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign x_o     = x_q[Stages-1];
  assign y_o     = y_q[Stages-1];
  assign z_o     = z_q[Stages-1];
  assign tag_o   = tag_q[Stages-1];

endmodule

FILE: hdl/sivp_div.sv
// Pipelined restoring divider, 64-bit unsigned, one quotient bit per stage.
// Uses sivp_pkg for the step count.
module sivp_div #(
  parameter int unsigned TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [63:0]     n_i,
  input  logic [63:0]     d_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [63:0]     q_o,
  output logic [TagW-1:0] tag_o
);

  localparam int unsigned Steps = sivp_pkg::DivSteps;

  logic [63:0]     rem_q [Steps], rem_in [Steps];
  logic [63:0]     nq_q  [Steps], nq_in  [Steps];
  logic [63:0]     d_q   [Steps], d_in   [Steps];
  logic            vld_q [Steps], vl_in  [Steps];
  logic [TagW-1:0] tag_q [Steps], t_in   [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [64:0] cand, diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in[k] = '0;
      assign nq_in[k]  = n_i;
      assign d_in[k]   = d_i;
      assign vl_in[k]  = valid_i;
      assign t_in[k]   = tag_i;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign nq_in[k]  = nq_q[k-1];
      assign d_in[k]   = d_q[k-1];
      assign vl_in[k]  = vld_q[k-1];
      assign t_in[k]   = tag_q[k-1];
    end

    // dividend bits shift out the top while quotient bits shift in below
    assign cand = {rem_in[k], nq_in[k][63]};
    assign diff = cand - {1'b0, d_in[k]};
    assign ge   = !diff[64];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vl_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[63:0] : cand[63:0];
      nq_q[k]  <= {nq_in[k][62:0], ge};
      d_q[k]   <= d_in[k];
      tag_q[k] <= t_in[k];
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign q_o     = nq_q[Steps-1];
  assign tag_o   = tag_q[Steps-1];

endmodule

FILE: hdl/siemon_iv_projection.sv
// Siemon IV projection, forward or inverse per item, signed Q4.28 in and out.
// Takes one item in every cycle (busy_o stays low); each result appears on
// out_o with done_o high for one cycle, in input order. The latency is
// mostly set by the 64-step divider, the 32-step square root and the
// CORDIC chain. The receiver cannot stall the pipe.
// Uses sivp_pkg, sivp_mul, sivp_isqrt, sivp_cordic, sivp_div.
module siemon_iv_projection #(
  parameter int unsigned CordicStages = sivp_pkg::CordicStagesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sivp_pkg::in_t        in_i,
  output logic                 busy_o,
  output logic                 done_o,
  output sivp_pkg::out_t       out_o
);

`include "siemon_iv_projection_assert.svh"

  localparam int unsigned CW      = sivp_pkg::CoordW;
  localparam int unsigned FracW   = CW - 4;
  localparam int unsigned FracDn  = (FracW >= sivp_pkg::QF) ? FracW - sivp_pkg::QF : 0;
  localparam int unsigned FracUp  = (FracW >= sivp_pkg::QF) ? 0 : sivp_pkg::QF - FracW;
  localparam int unsigned CtxW    = $bits(sivp_pkg::ctx_t);
  localparam int unsigned M2W     = $bits(sivp_pkg::m2tag_t);
  localparam int unsigned DvW     = $bits(sivp_pkg::dvtag_t);
  localparam int unsigned Lat     = 109 + CordicStages;
  localparam sivp_pkg::q_t MaxW   = 64'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam sivp_pkg::q_t MinW   = -MaxW - 64'sd1;
  localparam logic [63:0] OneSq   = 64'd1 << (2 * sivp_pkg::QF);

  function automatic sivp_pkg::q_t to_int(input logic signed [CW-1:0] v);
    sivp_pkg::q_t e;
    e = 64'(v);
    to_int = (e >>> FracDn) <<< FracUp;
  endfunction

  // {saturated, value}
  function automatic logic [CW:0] to_out(input sivp_pkg::q_t v);
    sivp_pkg::q_t r;
    logic         sat;
    r   = v >>> FracUp;
    sat = 1'b0;
    if (r > (MaxW >>> FracDn)) begin
      r   = MaxW;
      sat = 1'b1;
    end else if (r < (MinW >>> FracDn)) begin
      r   = MinW;
      sat = 1'b1;
    end else begin
      r = r <<< FracDn;
    end
    to_out = {sat, r[CW-1:0]};
  endfunction

  // stage 1: input conversion
  logic             s1_v_q;
  sivp_pkg::ctx_t   s1_d, s1_q, m1_tag_d;
  sivp_pkg::q_t     hh, m1_a, m1_b, m1_p;
  logic             m1_v;
  logic [CtxW-1:0]  m1_tag_o;

  assign busy_o = 1'b0;

  always_comb begin
    s1_d       = '0;
    s1_d.op    = in_i.operation;
    s1_d.a     = to_int(in_i.coord_a);
    s1_d.h     = to_int(in_i.coord_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // first wrap of the half angle rides alongside the multiplier
  always_comb begin
    hh = s1_q.h >>> 1;
    if (hh > sivp_pkg::PiQ) begin
      hh = hh - sivp_pkg::TwoPiQ;
    end else if (hh < -sivp_pkg::PiQ) begin
      hh = hh + sivp_pkg::TwoPiQ;
    end
    m1_tag_d = s1_q;
    if (s1_q.op == sivp_pkg::OpFwd) begin
      m1_tag_d.h = hh;
    end
    m1_a = (s1_q.op == sivp_pkg::OpInv) ? s1_q.h : s1_q.a;
    m1_b = (s1_q.op == sivp_pkg::OpInv) ? sivp_pkg::IcyQ : sivp_pkg::CxQ;
  end

  sivp_mul #(.TagW(CtxW)) u_mul1 (
    .clk_i, .rst_ni,
    .valid_i(s1_v_q), .a_i(m1_a), .b_i(m1_b), .tag_i(m1_tag_d),
    .valid_o(m1_v), .p_o(m1_p), .tag_o(m1_tag_o)
  );

  // stage 2: quarter fold (fwd) or asin argument clamp (inv)
  sivp_pkg::ctx_t s2_d, s2_q;
  logic           s2_v_q;

  always_comb begin
    s2_d = sivp_pkg::ctx_t'(m1_tag_o);
    if (s2_d.op == sivp_pkg::OpFwd) begin
      s2_d.p = m1_p;
      if (s2_d.h > sivp_pkg::HalfPiQ) begin
        s2_d.h   = s2_d.h - sivp_pkg::PiQ;
        s2_d.neg = 1'b1;
      end else if (s2_d.h < -sivp_pkg::HalfPiQ) begin
        s2_d.h   = s2_d.h + sivp_pkg::PiQ;
        s2_d.neg = 1'b1;
      end
    end else begin
      s2_d.h = m1_p;
      if (m1_p > sivp_pkg::QOne) begin
        s2_d.h     = sivp_pkg::QOne;
        s2_d.clamp = 1'b1;
      end else if (m1_p < -sivp_pkg::QOne) begin
        s2_d.h     = -sivp_pkg::QOne;
        s2_d.clamp = 1'b1;
      end
    end
  end

  // stage 3: t squared
  sivp_pkg::ctx_t     s3_q;
  logic               s3_v_q;
  logic signed [31:0] t32;
  sivp_pkg::q_t       t2_d, t2_q;

  assign t32  = s2_q.h[31:0];
  assign t2_d = 64'(t32) * 64'(t32);

  // stage 4: square root operand and cos(phi) for the inverse
  sivp_pkg::ctx_t s4_d, s4_q;
  logic           s4_v_q;
  logic [63:0]    v4_d, v4_q;

  always_comb begin
    s4_d = s3_q;
    v4_d = OneSq - t2_q;
    if (s3_q.op == sivp_pkg::OpInv) begin
      s4_d.p = sivp_pkg::QOne - ((t2_q >>> sivp_pkg::QF) <<< 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s2_v_q <= m1_v;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
    s3_q <= s2_q;
    t2_q <= t2_d;
    s4_q <= s4_d;
    v4_q <= v4_d;
  end

  logic            sq_v;
  logic [63:0]     sq_r;
  logic [CtxW-1:0] sq_tag;

  sivp_isqrt #(.TagW(CtxW)) u_isqrt (
    .clk_i, .rst_ni,
    .valid_i(s4_v_q), .v_i(v4_q), .tag_i(s4_q),
    .valid_o(sq_v), .r_o(sq_r), .tag_o(sq_tag)
  );

  // CORDIC: rotation by the half angle, or vectoring of (w, t)
  sivp_pkg::ctx_t  cd_ctx;
  sivp_pkg::q_t    cx0, cy0, cz0, cx, cy, cz;
  logic            cd_v;
  logic [CtxW-1:0] cd_tag;

  always_comb begin
    cd_ctx   = sivp_pkg::ctx_t'(sq_tag);
    cd_ctx.w = sivp_pkg::q_t'(sq_r);
    cx0 = (cd_ctx.op == sivp_pkg::OpInv) ? cd_ctx.w : sivp_pkg::KQ;
    cy0 = (cd_ctx.op == sivp_pkg::OpInv) ? cd_ctx.h : 64'sd0;
    cz0 = (cd_ctx.op == sivp_pkg::OpInv) ? 64'sd0 : cd_ctx.h;
  end

  sivp_cordic #(.Stages(CordicStages), .TagW(CtxW)) u_cordic (
    .clk_i, .rst_ni,
    .valid_i(sq_v), .vec_i(cd_ctx.op), .x_i(cx0), .y_i(cy0), .z_i(cz0),
    .tag_i(cd_ctx),
    .valid_o(cd_v), .x_o(cx), .y_o(cy), .z_o(cz), .tag_o(cd_tag)
  );

  // stages 5-7: trig products and divisor
  sivp_pkg::ctx_t     s5_q, s6_q, s7_q, c5;
  logic               s5_v_q, s6_v_q, s7_v_q;
  sivp_pkg::q_t       c5_q, sn5_q, z5_q, c6_q, z6_q;
  sivp_pkg::q_t       cc_d, ss_d, ys_d, dn_d, cc_q, ss_q, ys_q, dn_q;
  sivp_pkg::q_t       cos7_q, rb7_q, den7_q;
  logic signed [31:0] c32, s32, p32, cx32, cy32;

  assign c5   = sivp_pkg::ctx_t'(cd_tag);
  assign c32  = c5_q[31:0];
  assign s32  = sn5_q[31:0];
  assign p32  = s5_q.p[31:0];
  assign cx32 = sivp_pkg::CxQ[31:0];
  assign cy32 = sivp_pkg::CyQ[31:0];
  assign cc_d = 64'(c32) * 64'(c32);
  assign ss_d = 64'(s32) * 64'(s32);
  assign ys_d = 64'(cy32) * 64'(s32);
  assign dn_d = 64'(cx32) * 64'(p32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else begin
      s5_v_q <= cd_v;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_q   <= c5;
    c5_q   <= c5.neg ? -cx : cx;
    sn5_q  <= c5.neg ? -cy : cy;
    z5_q   <= cz <<< 1;
    s6_q   <= s5_q;
    cc_q   <= cc_d;
    ss_q   <= ss_d;
    ys_q   <= ys_d;
    dn_q   <= dn_d;
    c6_q   <= c5_q;
    z6_q   <= z5_q;
    s7_q   <= s6_q;
    cos7_q <= (cc_q - ss_q) >>> sivp_pkg::QF;
    rb7_q  <= (s6_q.op == sivp_pkg::OpInv) ? z6_q : (ys_q >>> sivp_pkg::QF);
    den7_q <= (s6_q.op == sivp_pkg::OpInv) ? (dn_q >>> sivp_pkg::QF) : c6_q;
  end

  // numerator: Cx*lam*cos(phi) (fwd) or x*w (inv)
  sivp_pkg::m2tag_t m2_tag_d, m2t;
  sivp_pkg::q_t     m2_a, m2_b, num;
  logic             m2_v;
  logic [M2W-1:0]   m2_tag_o;

  always_comb begin
    m2_tag_d.op    = s7_q.op;
    m2_tag_d.clamp = s7_q.clamp;
    m2_tag_d.rb    = rb7_q;
    m2_tag_d.den   = den7_q;
    m2_a = (s7_q.op == sivp_pkg::OpInv) ? s7_q.a : s7_q.p;
    m2_b = (s7_q.op == sivp_pkg::OpInv) ? s7_q.w : cos7_q;
  end

  sivp_mul #(.TagW(M2W)) u_mul2 (
    .clk_i, .rst_ni,
    .valid_i(s7_v_q), .a_i(m2_a), .b_i(m2_b), .tag_i(m2_tag_d),
    .valid_o(m2_v), .p_o(num), .tag_o(m2_tag_o)
  );

  // stage 8: magnitudes and signs for the divider
  sivp_pkg::dvtag_t dv_d, dv_q, dvo;
  logic             s8_v_q, dv_v;
  logic [63:0]      un, ud, n8_q, d8_q, qu;
  logic [DvW-1:0]   dv_tag_o;

  assign m2t = sivp_pkg::m2tag_t'(m2_tag_o);
  assign un  = num[63] ? 64'(-num) : 64'(num);
  assign ud  = m2t.den[63] ? 64'(-m2t.den) : 64'(m2t.den);

  always_comb begin
    dv_d.op    = m2t.op;
    dv_d.clamp = m2t.clamp;
    dv_d.sgn   = num[63] != m2t.den[63];
    dv_d.dz    = ud == 64'd0;
    dv_d.nz    = num == 64'sd0;
    dv_d.nneg  = num[63];
    dv_d.rb    = m2t.rb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else begin
      s8_v_q <= m2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
    n8_q <= un << sivp_pkg::QF;
    d8_q <= ud;
  end

  sivp_div #(.TagW(DvW)) u_div (
    .clk_i, .rst_ni,
    .valid_i(s8_v_q), .n_i(n8_q), .d_i(d8_q), .tag_i(dv_q),
    .valid_o(dv_v), .q_o(qu), .tag_o(dv_tag_o)
  );

  // output stage: sign, pole handling, saturation, status
  sivp_pkg::q_t   ra, qs;
  logic [CW:0]    oa, ob;
  sivp_pkg::out_t out_d, out_q;
  logic           done_q, fwd_q, sat;

  assign dvo = sivp_pkg::dvtag_t'(dv_tag_o);
  assign qs  = sivp_pkg::q_t'(qu);

  always_comb begin
    if (dvo.dz) begin
      ra = dvo.nz ? 64'sd0 : (dvo.nneg ? -sivp_pkg::SatBig : sivp_pkg::SatBig);
    end else begin
      ra = dvo.sgn ? -qs : qs;
    end
    oa  = to_out(ra);
    ob  = to_out(dvo.rb);
    sat = dvo.dz || oa[CW] || ob[CW];
    out_d.out_a  = oa[CW-1:0];
    out_d.out_b  = ob[CW-1:0];
    out_d.status = sat ? sivp_pkg::StErr : (dvo.clamp ? sivp_pkg::StClamp : sivp_pkg::StOk);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    fwd_q <= dvo.op == sivp_pkg::OpFwd;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  `SIVP_ASSERT(a_latency, start_i && !busy_o |-> ##Lat done_o, "result missing after latency")
  `SIVP_NEVER(a_status_code, done_o && out_o.status > sivp_pkg::StErr, "undefined status")
  `SIVP_NEVER(a_fwd_no_clamp, done_o && fwd_q && out_o.status == sivp_pkg::StClamp, "fwd clamp")

endmodule
